// ===== hw/rtl/nirfd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// NEC IR frame decoder package
// Shared types and constants for the pulse-duration frame decoder.
// ----------------------------------------------------------------------------
package nirfd_pkg;

  localparam int TICKS_W   = 16;
  localparam int BOUND_W   = 10;
  localparam int BYTE_W    = 8;
  localparam int BIT_CNT_W = 3;
  localparam int CFG_IDX_W = 4;
  localparam int OUT_BYTES = 4;

  // Reset values of the duration windows, in 100 us ticks.
  localparam logic [BOUND_W-1:0] LEAD_MIN_RST   = 10'd132;
  localparam logic [BOUND_W-1:0] LEAD_MAX_RST   = 10'd138;
  localparam logic [BOUND_W-1:0] REPEAT_MIN_RST = 10'd112;
  localparam logic [BOUND_W-1:0] REPEAT_MAX_RST = 10'd118;
  localparam logic [BOUND_W-1:0] ZERO_MIN_RST   = 10'd7;
  localparam logic [BOUND_W-1:0] ZERO_MAX_RST   = 10'd13;
  localparam logic [BOUND_W-1:0] ONE_MIN_RST    = 10'd17;
  localparam logic [BOUND_W-1:0] ONE_MAX_RST    = 10'd23;

  // Last bit position within a byte.
  localparam logic [BIT_CNT_W-1:0] LAST_BIT = 3'd7;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEAD_MIN   = 4'd0,
    REG_LEAD_MAX   = 4'd1,
    REG_REPEAT_MIN = 4'd2,
    REG_REPEAT_MAX = 4'd3,
    REG_ZERO_MIN   = 4'd4,
    REG_ZERO_MAX   = 4'd5,
    REG_ONE_MIN    = 4'd6,
    REG_ONE_MAX    = 4'd7
  } cfg_reg_t;

  // Current duration windows.
  typedef struct packed {
    logic [BOUND_W-1:0] lead_min;
    logic [BOUND_W-1:0] lead_max;
    logic [BOUND_W-1:0] repeat_min;
    logic [BOUND_W-1:0] repeat_max;
    logic [BOUND_W-1:0] zero_min;
    logic [BOUND_W-1:0] zero_max;
    logic [BOUND_W-1:0] one_min;
    logic [BOUND_W-1:0] one_max;
  } cfg_t;

  // One decoded result beat.
  typedef struct packed {
    logic [OUT_BYTES-1:0][BYTE_W-1:0] frame_bytes;
    logic [BYTE_W-1:0]                repeat_count;
    logic                             is_repeat;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/nirfd_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// NEC IR decoder configuration registers
// Holds the eight duration-window bounds, written through a plain write port.
// ----------------------------------------------------------------------------
module nirfd_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write_en,
  input  wire logic [nirfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [nirfd_pkg::BOUND_W-1:0]   cfg_data,
  output nirfd_pkg::cfg_t                      cfg
);

  // Register writes; indexes past the last register are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lead_min   <= nirfd_pkg::LEAD_MIN_RST;
      cfg.lead_max   <= nirfd_pkg::LEAD_MAX_RST;
      cfg.repeat_min <= nirfd_pkg::REPEAT_MIN_RST;
      cfg.repeat_max <= nirfd_pkg::REPEAT_MAX_RST;
      cfg.zero_min   <= nirfd_pkg::ZERO_MIN_RST;
      cfg.zero_max   <= nirfd_pkg::ZERO_MAX_RST;
      cfg.one_min    <= nirfd_pkg::ONE_MIN_RST;
      cfg.one_max    <= nirfd_pkg::ONE_MAX_RST;
    end else if (cfg_write_en) begin
      case (cfg_index)
        nirfd_pkg::REG_LEAD_MIN:   cfg.lead_min   <= cfg_data;
        nirfd_pkg::REG_LEAD_MAX:   cfg.lead_max   <= cfg_data;
        nirfd_pkg::REG_REPEAT_MIN: cfg.repeat_min <= cfg_data;
        nirfd_pkg::REG_REPEAT_MAX: cfg.repeat_max <= cfg_data;
        nirfd_pkg::REG_ZERO_MIN:   cfg.zero_min   <= cfg_data;
        nirfd_pkg::REG_ZERO_MAX:   cfg.zero_max   <= cfg_data;
        nirfd_pkg::REG_ONE_MIN:    cfg.one_min    <= cfg_data;
        nirfd_pkg::REG_ONE_MAX:    cfg.one_max    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/nirfd_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// NEC IR decoder core
// Classifies one pulse duration at a time and updates the frame state.
// ----------------------------------------------------------------------------
module nirfd_core #(
  parameter int FRAME_BYTES = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         fire,
  input  wire logic [nirfd_pkg::TICKS_W-1:0] ticks,
  input  wire nirfd_pkg::cfg_t               cfg,
  output logic                               res_valid,
  output nirfd_pkg::result_t                 res
);

  localparam int IDX_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

  logic                                  receiving;
  logic                                  receiving_next;
  logic [nirfd_pkg::BIT_CNT_W-1:0]       bit_count;
  logic [nirfd_pkg::BIT_CNT_W-1:0]       bit_count_next;
  logic [IDX_W-1:0]                      byte_index;
  logic [IDX_W-1:0]                      byte_index_next;
  logic [nirfd_pkg::BYTE_W-1:0]          frame [FRAME_BYTES];
  logic [nirfd_pkg::BYTE_W-1:0]          frame_next [FRAME_BYTES];
  logic [nirfd_pkg::BYTE_W-1:0]          repeat_counter;
  logic [nirfd_pkg::BYTE_W-1:0]          repeat_counter_next;
  logic [nirfd_pkg::OUT_BYTES-1:0][nirfd_pkg::BYTE_W-1:0] emit_bytes;
  logic                                  is_lead;
  logic                                  is_repeat_code;
  logic                                  is_one;
  logic                                  is_zero;
  logic                                  emit_frame;
  logic                                  emit_repeat;

  // Window checks, bounds inclusive.
  function automatic logic in_window(
    input logic [nirfd_pkg::TICKS_W-1:0] t,
    input logic [nirfd_pkg::BOUND_W-1:0] lo,
    input logic [nirfd_pkg::BOUND_W-1:0] hi
  );
    logic [nirfd_pkg::TICKS_W-1:0] lo_x;
    logic [nirfd_pkg::TICKS_W-1:0] hi_x;
    lo_x = nirfd_pkg::TICKS_W'(lo);
    hi_x = nirfd_pkg::TICKS_W'(hi);
    return (t >= lo_x) && (t <= hi_x);
  endfunction

  assign is_lead        = in_window(ticks, cfg.lead_min, cfg.lead_max);
  assign is_repeat_code = in_window(ticks, cfg.repeat_min, cfg.repeat_max);
  assign is_one         = in_window(ticks, cfg.one_min, cfg.one_max);
  assign is_zero        = !is_one && in_window(ticks, cfg.zero_min, cfg.zero_max);

  // Next-state logic for one pulse.
  always_comb begin
    receiving_next      = receiving;
    bit_count_next      = bit_count;
    byte_index_next     = byte_index;
    repeat_counter_next = repeat_counter;
    frame_next          = frame;
    emit_frame          = 1'b0;
    emit_repeat         = 1'b0;
    if (fire) begin
      if (!receiving) begin
        if (is_lead) begin
          receiving_next      = 1'b1;
          bit_count_next      = '0;
          byte_index_next     = '0;
          repeat_counter_next = '0;
        end else if (is_repeat_code) begin
          repeat_counter_next = repeat_counter + 8'd1;
          emit_repeat         = 1'b1;
        end
      end else if (!is_one && !is_zero) begin
        // Bad bit period: drop back to idle, keep the partial bytes.
        receiving_next  = 1'b0;
        bit_count_next  = '0;
        byte_index_next = '0;
      end else begin
        frame_next[byte_index] = {is_one, frame[byte_index][nirfd_pkg::BYTE_W-1:1]};
        bit_count_next = bit_count + 3'd1;
        if (bit_count == nirfd_pkg::LAST_BIT) begin
          if (byte_index == LAST_IDX) begin
            receiving_next  = 1'b0;
            byte_index_next = '0;
            emit_frame      = 1'b1;
          end else begin
            byte_index_next = byte_index + IDX_W'(1);
          end
        end
      end
    end
  end

  // Reported bytes; positions past the frame length read as zero.
  for (genvar k = 0; k < nirfd_pkg::OUT_BYTES; k++) begin : g_emit
    if (k < FRAME_BYTES) begin : g_have
      assign emit_bytes[k] = frame_next[k];
    end else begin : g_none
      assign emit_bytes[k] = '0;
    end
  end

  assign res_valid        = emit_frame || emit_repeat;
  assign res.frame_bytes  = emit_bytes;
  assign res.repeat_count = repeat_counter_next;
  assign res.is_repeat    = emit_repeat;

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      receiving      <= 1'b0;
      bit_count      <= '0;
      byte_index     <= '0;
      repeat_counter <= '0;
      for (int i = 0; i < FRAME_BYTES; i++) begin
        frame[i] <= '0;
      end
    end else begin
      receiving      <= receiving_next;
      bit_count      <= bit_count_next;
      byte_index     <= byte_index_next;
      repeat_counter <= repeat_counter_next;
      frame          <= frame_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/nec_ir_frame_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// NEC IR frame decoder
// Decodes NEC frames and repeat codes from measured pulse-pair durations.
// ----------------------------------------------------------------------------
// The decoder takes one pulse duration per clock cycle while pulse_stall is low.
// A pulse passes through the input register; the core's state update then
// writes the result beat into the output register.
// Only a completed frame or a repeat code produces a beat. While a result
// waits on frame_stall, one more pulse is taken and held in the input
// register; pulse_stall then rises until the result is taken.
module nec_ir_frame_decoder #(
  parameter int FRAME_BYTES = 4
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write_en,
  input  wire logic [nirfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [nirfd_pkg::BOUND_W-1:0]   cfg_data,
  input  wire logic                            pulse_valid,
  output logic                                 pulse_stall,
  input  wire logic [nirfd_pkg::TICKS_W-1:0]   pulse_ticks,
  output logic                                 frame_valid,
  input  wire logic                            frame_stall,
  output logic [nirfd_pkg::BYTE_W-1:0]         address_byte,
  output logic [nirfd_pkg::BYTE_W-1:0]         address_inv_byte,
  output logic [nirfd_pkg::BYTE_W-1:0]         command_byte,
  output logic [nirfd_pkg::BYTE_W-1:0]         command_inv_byte,
  output logic [nirfd_pkg::BYTE_W-1:0]         repeat_count,
  output logic                                 is_repeat
);

  nirfd_pkg::cfg_t                  cfg;
  nirfd_pkg::result_t               res;
  nirfd_pkg::result_t               out_res;
  logic                             res_valid;
  logic                             s1_valid;
  logic [nirfd_pkg::TICKS_W-1:0]    s1_ticks;
  logic                             advance;
  logic                             fire;

  nirfd_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg)
  );

  // The core runs whenever the output register is empty or being drained.
  assign advance     = !frame_valid || !frame_stall;
  assign fire        = s1_valid && advance;
  assign pulse_stall = s1_valid && !advance;

  nirfd_core #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .ticks     (s1_ticks),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!pulse_stall) begin
      s1_valid <= pulse_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pulse_valid && !pulse_stall) begin
      s1_ticks <= pulse_ticks;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (advance) begin
      frame_valid <= fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      out_res <= res;
    end
  end

  assign address_byte     = out_res.frame_bytes[0];
  assign address_inv_byte = out_res.frame_bytes[1];
  assign command_byte     = out_res.frame_bytes[2];
  assign command_inv_byte = out_res.frame_bytes[3];
  assign repeat_count     = out_res.repeat_count;
  assign is_repeat        = out_res.is_repeat;

endmodule

`default_nettype wire

// ===== hw/rtl/nirfd_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// NEC IR decoder port checker
// Checks port behavior of the decoder over time; bound to the top level.
// ----------------------------------------------------------------------------
module nirfd_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            pulse_valid,
  input wire logic                            pulse_stall,
  input wire logic                            frame_valid,
  input wire logic                            frame_stall,
  input wire logic [nirfd_pkg::BYTE_W-1:0]    address_byte,
  input wire logic [nirfd_pkg::BYTE_W-1:0]    command_byte,
  input wire logic [nirfd_pkg::BYTE_W-1:0]    repeat_count,
  input wire logic                            is_repeat
);

  // A fresh result beat comes from a pulse taken on the pulse input.
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(frame_valid) |-> $past(pulse_valid && !pulse_stall, 2))
    else $error("result beat without a pulse two cycles earlier");

  // The decoder only pushes back while a result beat is held up.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    pulse_stall |-> (frame_valid && frame_stall))
    else $error("pulse stalled while the output side is free");

  // A full frame always follows a lead code, which clears the repeat count.
  a_frame_count: assert property (@(posedge clk) disable iff (rst)
    (frame_valid && !is_repeat) |-> (repeat_count == '0))
    else $error("full frame reported with a nonzero repeat count");

  // A held result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (frame_valid && frame_stall) |=>
      (frame_valid && $stable(address_byte) && $stable(command_byte) &&
       $stable(repeat_count) && $stable(is_repeat)))
    else $error("stalled result beat changed");

endmodule

bind nec_ir_frame_decoder nirfd_checker u_nirfd_checker (
  .clk          (clk),
  .rst          (rst),
  .pulse_valid  (pulse_valid),
  .pulse_stall  (pulse_stall),
  .frame_valid  (frame_valid),
  .frame_stall  (frame_stall),
  .address_byte (address_byte),
  .command_byte (command_byte),
  .repeat_count (repeat_count),
  .is_repeat    (is_repeat)
);

`default_nettype wire
